// ===== sv/lmc_accumulator_processor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator processor
// Shared property forms; clock and reset are taken from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef LMC_ACCUMULATOR_PROCESSOR_DEFINES_SVH
`define LMC_ACCUMULATOR_PROCESSOR_DEFINES_SVH

// condition must hold at every edge out of reset
`define LMC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define LMC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg
// Widths, operation and instruction codes, decode constants and the
// command/status structs shared by the processor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

   // mailbox count and derived widths
   localparam int MAILBOX_COUNT = 100;
   localparam int IDX_W         = $clog2(MAILBOX_COUNT);
   localparam int WORD_W        = 16;
   localparam int PC_W          = 7;
   localparam int OP_W          = 2;
   localparam int OPC_W         = 4;
   localparam int ARG_W         = 7;
   localparam int CODE_W        = OPC_W + ARG_W;

   // end-of-program PC value
   localparam logic [PC_W-1:0] MAILBOX_END = PC_W'(MAILBOX_COUNT);

   // decimal decode: word mod 1000, then hundreds digit and remainder
   localparam int DEC_BASE    = 1000;
   localparam int DIGIT_BASE  = 100;
   localparam int DIGIT_COUNT = DEC_BASE / DIGIT_BASE;
   localparam int REM_W       = $clog2(DEC_BASE);
   localparam int QUOT_W      = $clog2((1 << WORD_W) / DEC_BASE + 1);
   // floor(v / 1000) == (v * RECIP_MUL) >> RECIP_SHIFT for every 16-bit v
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = 17;
   localparam int PROD_W      = WORD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(67109);

   // item operations
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // instruction opcodes
   localparam logic [OPC_W-1:0] INS_HLT = 4'd0;
   localparam logic [OPC_W-1:0] INS_ADD = 4'd1;
   localparam logic [OPC_W-1:0] INS_SUB = 4'd2;
   localparam logic [OPC_W-1:0] INS_STA = 4'd3;
   localparam logic [OPC_W-1:0] INS_LDA = 4'd5;
   localparam logic [OPC_W-1:0] INS_BRA = 4'd6;
   localparam logic [OPC_W-1:0] INS_BRZ = 4'd7;
   localparam logic [OPC_W-1:0] INS_BRP = 4'd8;
   localparam logic [OPC_W-1:0] INS_IO  = 4'd9;

   // operands of the I/O opcode
   localparam logic [ARG_W-1:0] IO_INP = 7'd1;
   localparam logic [ARG_W-1:0] IO_OUT = 7'd2;

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture the accepted item
      logic div;       // quotient of write value by 1000
      logic rem;       // remainder of write value by 1000
      logic rd_addr;   // data read at item address
      logic rd_code;   // code read at PC
      logic rd_arg;    // data read at instruction operand
      logic exec;      // commit the item's effect
      logic load_rsp;  // load the result register
   } lmc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            out_free;
   } lmc_sts_type;

endpackage

`default_nettype wire

// ===== sv/lmc_req_if.sv =====
// ----------------------------------------------------------------------------
// lmc_req_if
// Request channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lmc_pkg::OP_W-1:0]    operation;
   logic [lmc_pkg::PC_W-1:0]    address;
   logic [lmc_pkg::WORD_W-1:0]  write_value;
   logic [lmc_pkg::WORD_W-1:0]  input_value;

   modport source (output valid, output operation, output address,
                   output write_value, output input_value, input ready);
   modport sink   (input valid, input operation, input address,
                   input write_value, input input_value, output ready);
endinterface

`default_nettype wire

// ===== sv/lmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lmc_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lmc_pkg::WORD_W-1:0]  read_value;
   logic [lmc_pkg::PC_W-1:0]    program_counter;
   logic [lmc_pkg::WORD_W-1:0]  accumulator_value;
   logic                        negative_flag;
   logic                        output_valid;
   logic                        input_taken;
   logic                        halted;

   modport source (output valid, output read_value, output program_counter,
                   output accumulator_value, output negative_flag,
                   output output_valid, output input_taken, output halted,
                   input ready);
   modport sink   (input valid, input read_value, input program_counter,
                   input accumulator_value, input negative_flag,
                   input output_valid, input input_taken, input halted,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/lmc_ram.sv =====
// ----------------------------------------------------------------------------
// lmc_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/lmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmc_ctrl
// Sequencer: accepts one item, steps the datapath through its memory
// reads or decode steps and commit, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lmc_accumulator_processor_defines.svh"

module lmc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire lmc_pkg::lmc_sts_type sts,
   output      lmc_pkg::lmc_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_REM   = 3'd2;
   localparam logic [2:0] S_OPER  = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (sts.op == lmc_pkg::OP_WRITE)     state_in = S_REM;
            else if (sts.op == lmc_pkg::OP_STEP) state_in = S_OPER;
            else                                 state_in = S_EXEC;
         end
         S_REM:  state_in = S_EXEC;
         S_OPER: state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.latch    = (state_ff == S_IDLE) && req_valid;
      cmd.div      = (state_ff == S_ISSUE) && (sts.op == lmc_pkg::OP_WRITE);
      cmd.rd_addr  = (state_ff == S_ISSUE) && (sts.op == lmc_pkg::OP_READ);
      cmd.rd_code  = (state_ff == S_ISSUE) && (sts.op == lmc_pkg::OP_STEP);
      cmd.rem      = (state_ff == S_REM);
      cmd.rd_arg   = (state_ff == S_OPER);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.load_rsp = (state_ff == S_RESP) && sts.out_free;
   end

   `LMC_ASSERT_NEXT(a_accept_issue, req_valid && req_ready, state_ff == S_ISSUE, "accepted item did not start")
   `LMC_ASSERT_NEXT(a_exec_resp, state_ff == S_EXEC, state_ff == S_RESP, "commit not followed by response")
   `LMC_ASSERT_NEXT(a_resp_hold, (state_ff == S_RESP) && !sts.out_free, state_ff == S_RESP, "result dropped while output busy")

endmodule

`default_nettype wire

// ===== sv/lmc_dpath.sv =====
// ----------------------------------------------------------------------------
// lmc_dpath
// Datapath: item latch, mod-1000 decoder, data and code mailboxes,
// accumulator machine registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lmc_accumulator_processor_defines.svh"

module lmc_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lmc_pkg::lmc_cmd_type          cmd,
   output      lmc_pkg::lmc_sts_type          sts,
   input  wire logic [lmc_pkg::OP_W-1:0]      in_operation,
   input  wire logic [lmc_pkg::PC_W-1:0]      in_address,
   input  wire logic [lmc_pkg::WORD_W-1:0]    in_write_value,
   input  wire logic [lmc_pkg::WORD_W-1:0]    in_input_value,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [lmc_pkg::WORD_W-1:0]    out_read_value,
   output      logic [lmc_pkg::PC_W-1:0]      out_program_counter,
   output      logic [lmc_pkg::WORD_W-1:0]    out_accumulator_value,
   output      logic                          out_negative_flag,
   output      logic                          out_output_valid,
   output      logic                          out_input_taken,
   output      logic                          out_halted
);

   // latched item
   logic [lmc_pkg::OP_W-1:0]    op_ff;
   logic [lmc_pkg::PC_W-1:0]    addr_ff;
   logic [lmc_pkg::WORD_W-1:0]  wval_ff;
   logic [lmc_pkg::WORD_W-1:0]  ival_ff;

   // decode pipeline
   logic [lmc_pkg::PROD_W-1:0]  prod;
   logic [lmc_pkg::QUOT_W-1:0]  quot_ff;
   logic [lmc_pkg::REM_W-1:0]   rem_ff;
   logic [lmc_pkg::OPC_W-1:0]   dec_opc;
   logic [lmc_pkg::ARG_W-1:0]   dec_arg;

   // machine registers
   logic [lmc_pkg::PC_W-1:0]    pc_ff,   pc_in;
   logic [lmc_pkg::WORD_W-1:0]  acc_ff,  acc_in;
   logic                        neg_ff,  neg_in;
   logic                        halt_ff, halt_in;
   logic                        outv_ff, outv_in;
   logic                        inv_ff,  inv_in;

   // mailbox control
   logic [lmc_pkg::MAILBOX_COUNT-1:0] data_vld_ff;
   logic [lmc_pkg::MAILBOX_COUNT-1:0] code_vld_ff;
   logic                        data_ok_ff;
   logic                        code_ok_ff;
   logic                        addr_ok;
   logic                        pc_ok;
   logic                        arg_ok;
   logic [lmc_pkg::IDX_W-1:0]   addr_idx;
   logic [lmc_pkg::IDX_W-1:0]   pc_idx;
   logic [lmc_pkg::IDX_W-1:0]   arg_idx;
   logic                        wr_commit;
   logic                        sta_we;
   logic                        data_we;
   logic [lmc_pkg::IDX_W-1:0]   data_waddr;
   logic [lmc_pkg::WORD_W-1:0]  data_wdata;
   logic                        data_re;
   logic [lmc_pkg::IDX_W-1:0]   data_raddr;
   logic [lmc_pkg::WORD_W-1:0]  data_dout;
   logic                        code_re;
   logic [lmc_pkg::CODE_W-1:0]  code_dout;
   logic [lmc_pkg::CODE_W-1:0]  code_word;
   logic [lmc_pkg::OPC_W-1:0]   ins_opc;
   logic [lmc_pkg::ARG_W-1:0]   ins_arg;
   logic [lmc_pkg::WORD_W-1:0]  mval;
   logic [lmc_pkg::PC_W-1:0]    seq_pc;
   logic [lmc_pkg::PC_W-1:0]    tgt;

   logic                        rsp_valid_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= in_operation;
         addr_ff <= in_address;
         wval_ff <= in_write_value;
         ival_ff <= in_input_value;
      end
   end

   // write value mod 1000: reciprocal multiply, then subtract
   assign prod = lmc_pkg::PROD_W'(wval_ff) * lmc_pkg::PROD_W'(lmc_pkg::RECIP_MUL);

   always_ff @(posedge clock) begin
      if (cmd.div) begin
         quot_ff <= lmc_pkg::QUOT_W'(prod >> lmc_pkg::RECIP_SHIFT);
      end
      if (cmd.rem) begin
         rem_ff <= lmc_pkg::REM_W'(wval_ff - lmc_pkg::WORD_W'(quot_ff)
                                   * lmc_pkg::WORD_W'(lmc_pkg::DEC_BASE));
      end
   end

   // hundreds digit by threshold compares, operand is what is left
   always_comb begin
      dec_opc = '0;
      for (int k = 1; k < lmc_pkg::DIGIT_COUNT; k++) begin
         if (rem_ff >= lmc_pkg::REM_W'(k * lmc_pkg::DIGIT_BASE)) begin
            dec_opc = lmc_pkg::OPC_W'(k);
         end
      end
      dec_arg = lmc_pkg::ARG_W'(rem_ff - lmc_pkg::REM_W'(dec_opc * lmc_pkg::DIGIT_BASE));
   end

   // range checks and indexes
   assign addr_ok  = (addr_ff < lmc_pkg::MAILBOX_END);
   assign pc_ok    = (pc_ff < lmc_pkg::MAILBOX_END);
   assign addr_idx = addr_ff[lmc_pkg::IDX_W-1:0];
   assign pc_idx   = pc_ff[lmc_pkg::IDX_W-1:0];

   // fetched instruction; an unwritten mailbox decodes to halt
   assign code_word = code_ok_ff ? code_dout : '0;
   assign ins_opc   = code_word[lmc_pkg::CODE_W-1:lmc_pkg::ARG_W];
   assign ins_arg   = code_word[lmc_pkg::ARG_W-1:0];
   assign arg_ok    = (ins_arg < lmc_pkg::MAILBOX_END);
   assign arg_idx   = ins_arg[lmc_pkg::IDX_W-1:0];
   assign mval      = data_ok_ff ? data_dout : '0;

   // mailbox ports
   assign wr_commit  = cmd.exec && (op_ff == lmc_pkg::OP_WRITE) && addr_ok;
   assign data_we    = wr_commit || sta_we;
   assign data_waddr = wr_commit ? addr_idx : arg_idx;
   assign data_wdata = wr_commit ? wval_ff : acc_ff;
   assign data_re    = (cmd.rd_addr && addr_ok) || (cmd.rd_arg && arg_ok);
   assign data_raddr = cmd.rd_addr ? addr_idx : arg_idx;
   assign code_re    = cmd.rd_code && pc_ok;

   lmc_ram #(
      .WIDTH (lmc_pkg::WORD_W),
      .DEPTH (lmc_pkg::MAILBOX_COUNT)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (data_waddr),
      .wdata (data_wdata),
      .re    (data_re),
      .raddr (data_raddr),
      .rdata (data_dout)
   );

   lmc_ram #(
      .WIDTH (lmc_pkg::CODE_W),
      .DEPTH (lmc_pkg::MAILBOX_COUNT)
   ) u_code_ram (
      .clock (clock),
      .we    (wr_commit),
      .waddr (addr_idx),
      .wdata ({dec_opc, dec_arg}),
      .re    (code_re),
      .raddr (pc_idx),
      .rdata (code_dout)
   );

   // read qualifiers: in range and written since reset
   always_ff @(posedge clock) begin
      if (cmd.rd_addr) begin
         data_ok_ff <= addr_ok && data_vld_ff[addr_idx];
      end else if (cmd.rd_arg) begin
         data_ok_ff <= arg_ok && data_vld_ff[arg_idx];
      end
      if (cmd.rd_code) begin
         code_ok_ff <= pc_ok && code_vld_ff[pc_idx];
      end
   end

   // valid bits stand in for the all-zero reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= '0;
         code_vld_ff <= '0;
      end else begin
         if (data_we) data_vld_ff[data_waddr] <= 1'b1;
         if (wr_commit) code_vld_ff[addr_idx] <= 1'b1;
      end
   end

   // instruction execute and run start
   always_comb begin
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      pc_in   = pc_ff;
      halt_in = halt_ff;
      outv_in = outv_ff;
      inv_in  = inv_ff;
      sta_we  = 1'b0;
      seq_pc  = pc_ff + lmc_pkg::PC_W'(1);
      tgt     = seq_pc;
      if (cmd.latch) begin
         outv_in = 1'b0;
         inv_in  = 1'b0;
      end
      if (cmd.exec && (op_ff == lmc_pkg::OP_START)) begin
         acc_in  = '0;
         neg_in  = 1'b0;
         pc_in   = '0;
         halt_in = 1'b0;
      end
      if (cmd.exec && (op_ff == lmc_pkg::OP_STEP) && !halt_ff) begin
         case (ins_opc)
            lmc_pkg::INS_HLT: tgt = lmc_pkg::MAILBOX_END;
            lmc_pkg::INS_ADD: acc_in = acc_ff + mval;
            lmc_pkg::INS_SUB: begin
               neg_in = (mval > acc_ff);
               acc_in = acc_ff - mval;
            end
            lmc_pkg::INS_STA: sta_we = arg_ok;
            lmc_pkg::INS_LDA: acc_in = mval;
            lmc_pkg::INS_BRA: tgt = ins_arg;
            lmc_pkg::INS_BRZ: begin
               if (acc_ff == '0) tgt = ins_arg;
            end
            lmc_pkg::INS_BRP: begin
               if (!neg_ff) tgt = ins_arg;
            end
            lmc_pkg::INS_IO: begin
               if (ins_arg == lmc_pkg::IO_INP) begin
                  acc_in = ival_ff;
                  inv_in = 1'b1;
               end else if (ins_arg == lmc_pkg::IO_OUT) begin
                  outv_in = 1'b1;
               end
            end
            default: tgt = seq_pc;
         endcase
         // running past the last mailbox stops the machine
         if (tgt >= lmc_pkg::MAILBOX_END) begin
            pc_in   = lmc_pkg::MAILBOX_END;
            halt_in = 1'b1;
         end else begin
            pc_in = tgt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         acc_ff  <= '0;
         neg_ff  <= 1'b0;
         halt_ff <= 1'b1;
         outv_ff <= 1'b0;
         inv_ff  <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         acc_ff  <= acc_in;
         neg_ff  <= neg_in;
         halt_ff <= halt_in;
         outv_ff <= outv_in;
         inv_ff  <= inv_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_read_value        <= ((op_ff == lmc_pkg::OP_READ) && data_ok_ff) ? data_dout : '0;
         out_program_counter   <= pc_ff;
         out_accumulator_value <= acc_ff;
         out_negative_flag     <= neg_ff;
         out_output_valid      <= outv_ff;
         out_input_taken       <= inv_ff;
         out_halted            <= halt_ff;
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign sts.op       = op_ff;
   assign sts.out_free = !rsp_valid_ff || out_ready;

   `LMC_ASSERT_ALWAYS(a_pc_range, pc_ff <= lmc_pkg::MAILBOX_END, "PC beyond end of program")
   `LMC_ASSERT_IMPLIES(a_run_pc, !halt_ff, pc_ff < lmc_pkg::MAILBOX_END, "running with PC at end")
   `LMC_ASSERT_IMPLIES(a_dec_range, cmd.exec && (op_ff == lmc_pkg::OP_WRITE), rem_ff < lmc_pkg::REM_W'(lmc_pkg::DEC_BASE), "mod 1000 result out of range")

endmodule

`default_nettype wire

// ===== sv/lmc_accumulator_processor.sv =====
// Sequence: start and read items pass issue, commit and response states; write
// and step items add a remainder or operand-read state, and the response state
// holds while rsp is stalled. A new item is accepted only once the last result
// is loaded; a step is bound by the chained code-mailbox then data-mailbox reads,
// a write by the two-stage mod-1000 decode. Reset: synchronous; all mailboxes
// read zero, the machine is halted with PC 0, no clearing pass.
// ----------------------------------------------------------------------------
// lmc_accumulator_processor
// Mailbox machine with a 16-bit accumulator: write, start, step and read
// items, one result per item. Controller and datapath joined by cmd/status.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_accumulator_processor (
   input  wire logic  clock,
   input  wire logic  reset,
   lmc_req_if.sink    req_chan,
   lmc_rsp_if.source  rsp_chan
);

   lmc_pkg::lmc_cmd_type cmd;
   lmc_pkg::lmc_sts_type sts;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   // sequencer
   lmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // mailboxes, machine registers, result register
   lmc_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .in_operation          (req_chan.operation),
      .in_address            (req_chan.address),
      .in_write_value        (req_chan.write_value),
      .in_input_value        (req_chan.input_value),
      .out_valid             (rsp_chan.valid),
      .out_ready             (rsp_chan.ready),
      .out_read_value        (rsp_chan.read_value),
      .out_program_counter   (rsp_chan.program_counter),
      .out_accumulator_value (rsp_chan.accumulator_value),
      .out_negative_flag     (rsp_chan.negative_flag),
      .out_output_valid      (rsp_chan.output_valid),
      .out_input_taken       (rsp_chan.input_taken),
      .out_halted            (rsp_chan.halted)
   );

endmodule

`default_nettype wire

// ===== verif/tb_lmc_accumulator_processor.sv =====
// ----------------------------------------------------------------------------
// tb_lmc_accumulator_processor
// Self-checking bench for the mailbox machine. A directed table covers reset
// state, out-of-range mailboxes and one short program run by single steps.
// Random programs follow: small programs are loaded, started and stepped,
// mixed with reads, writes into running code and stray items. Every result
// is checked against a typed row's own result or a bench copy of the machine.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lmc_accumulator_processor;

   localparam int ITEM_TARGET   = 1850;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_ITEM  = 300;
   localparam int REPORT_LIMIT  = 10;

   // one result item as seen on the rsp channel
   typedef struct packed {
      logic [lmc_pkg::WORD_W-1:0] read_value;
      logic [lmc_pkg::PC_W-1:0]   program_counter;
      logic [lmc_pkg::WORD_W-1:0] accumulator_value;
      logic                       negative_flag;
      logic                       output_valid;
      logic                       input_taken;
      logic                       halted;
   } lmc_result_type;

   // one row of the directed table; typed rows carry their own result
   typedef struct packed {
      logic [lmc_pkg::OP_W-1:0]   op;
      logic [lmc_pkg::PC_W-1:0]   addr;
      logic [lmc_pkg::WORD_W-1:0] wval;
      logic [lmc_pkg::WORD_W-1:0] ival;
      logic                       typed;
      lmc_result_type             want;
   } dir_row_type;

   localparam lmc_result_type NO_WANT      = '0;
   // halted at PC 0 with everything clear, as after reset
   localparam lmc_result_type RESET_IDLE   = '{16'd0, 7'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1};
   // running at PC 0 with everything clear
   localparam lmc_result_type JUST_STARTED = '0;

   // program: INP, ADD 10, SUB 11, OUT, BRP 20, no-op, BRA 99 ... 99: I/O no-op
   localparam dir_row_type DIRECTED_ROWS [25] = '{
      '{lmc_pkg::OP_READ,  7'd0,   16'd0,     16'd0,     1'b1, RESET_IDLE},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b1, RESET_IDLE},
      '{lmc_pkg::OP_READ,  7'd127, 16'hFFFF,  16'hFFFF,  1'b1, RESET_IDLE},
      '{lmc_pkg::OP_WRITE, 7'd127, 16'hFFFF,  16'd0,     1'b1, RESET_IDLE},
      '{lmc_pkg::OP_READ,  7'd99,  16'd0,     16'd0,     1'b1, RESET_IDLE},
      '{lmc_pkg::OP_WRITE, 7'd0,   16'd901,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd1,   16'd110,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd2,   16'd211,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd3,   16'd902,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd4,   16'd820,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd5,   16'd499,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd6,   16'd6699,  16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd10,  16'hFFFF,  16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd11,  16'd9,     16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_WRITE, 7'd99,  16'd903,   16'd0,     1'b0, NO_WANT},
      '{lmc_pkg::OP_START, 7'd0,   16'd0,     16'd0,     1'b1, JUST_STARTED},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'd5,     1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_STEP,  7'd0,   16'd0,     16'hFFFF,  1'b0, NO_WANT},
      '{lmc_pkg::OP_READ,  7'd10,  16'd0,     16'd0,     1'b0, NO_WANT}
   };

   logic clock;
   logic reset;

   lmc_req_if req_bus ();
   lmc_rsp_if rsp_bus ();

   lmc_accumulator_processor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // bench copy of the machine
   logic [lmc_pkg::WORD_W-1:0] data_mem [lmc_pkg::MAILBOX_COUNT];
   logic [lmc_pkg::OPC_W-1:0]  code_opc [lmc_pkg::MAILBOX_COUNT];
   logic [lmc_pkg::ARG_W-1:0]  code_arg [lmc_pkg::MAILBOX_COUNT];
   logic [lmc_pkg::PC_W-1:0]   mach_pc;
   logic [lmc_pkg::WORD_W-1:0] mach_acc;
   logic                       mach_neg;
   logic                       mach_halt;

   lmc_result_type awaited_results [$];

   int items_sent;
   int fault_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_left;
   int idle_cycles;
   logic hold_done;

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // apply one item to the bench machine and return the result it gives
   function automatic lmc_result_type mailbox_machine_step(
         input logic [lmc_pkg::OP_W-1:0]   op,
         input logic [lmc_pkg::PC_W-1:0]   addr,
         input logic [lmc_pkg::WORD_W-1:0] wval,
         input logic [lmc_pkg::WORD_W-1:0] ival);
      lmc_result_type             r;
      int unsigned                dec;
      int unsigned                target;
      logic [lmc_pkg::OPC_W-1:0]  opc;
      logic [lmc_pkg::ARG_W-1:0]  arg;
      logic [lmc_pkg::WORD_W-1:0] operand;
      r = '0;
      case (op)
         lmc_pkg::OP_WRITE: begin
            if (addr < lmc_pkg::MAILBOX_COUNT) begin
               dec = wval % lmc_pkg::DEC_BASE;
               data_mem[addr] = wval;
               code_opc[addr] = lmc_pkg::OPC_W'(dec / lmc_pkg::DIGIT_BASE);
               code_arg[addr] = lmc_pkg::ARG_W'(dec % lmc_pkg::DIGIT_BASE);
            end
         end
         lmc_pkg::OP_START: begin
            mach_pc   = '0;
            mach_acc  = '0;
            mach_neg  = 1'b0;
            mach_halt = 1'b0;
         end
         lmc_pkg::OP_STEP: begin
            if (!mach_halt) begin
               if (mach_pc >= lmc_pkg::MAILBOX_COUNT) begin
                  mach_pc   = lmc_pkg::MAILBOX_END;
                  mach_halt = 1'b1;
               end else begin
                  opc     = code_opc[mach_pc];
                  arg     = code_arg[mach_pc];
                  operand = (arg < lmc_pkg::MAILBOX_COUNT) ? data_mem[arg] : '0;
                  target  = mach_pc + 1;
                  case (opc)
                     lmc_pkg::INS_HLT: target = lmc_pkg::MAILBOX_COUNT;
                     lmc_pkg::INS_ADD: mach_acc = mach_acc + operand;
                     lmc_pkg::INS_SUB: begin
                        mach_neg = (operand > mach_acc);
                        mach_acc = mach_acc - operand;
                     end
                     lmc_pkg::INS_STA: begin
                        if (arg < lmc_pkg::MAILBOX_COUNT) data_mem[arg] = mach_acc;
                     end
                     lmc_pkg::INS_LDA: mach_acc = operand;
                     lmc_pkg::INS_BRA: target = arg;
                     lmc_pkg::INS_BRZ: if (mach_acc == '0) target = arg;
                     lmc_pkg::INS_BRP: if (!mach_neg) target = arg;
                     lmc_pkg::INS_IO: begin
                        if (arg == lmc_pkg::IO_INP) begin
                           mach_acc      = ival;
                           r.input_taken = 1'b1;
                        end else if (arg == lmc_pkg::IO_OUT) begin
                           r.output_valid = 1'b1;
                        end
                     end
                     default: ;
                  endcase
                  if (target >= lmc_pkg::MAILBOX_COUNT) begin
                     mach_pc   = lmc_pkg::MAILBOX_END;
                     mach_halt = 1'b1;
                  end else begin
                     mach_pc = lmc_pkg::PC_W'(target);
                  end
               end
            end
         end
         lmc_pkg::OP_READ:
            r.read_value = (addr < lmc_pkg::MAILBOX_COUNT) ? data_mem[addr] : '0;
         default: ;
      endcase
      r.program_counter   = mach_pc;
      r.accumulator_value = mach_acc;
      r.negative_flag     = mach_neg;
      r.halted            = mach_halt;
      return r;
   endfunction

   // instruction word: random thousands, an opcode digit and an operand near the program
   function automatic logic [lmc_pkg::WORD_W-1:0] random_instr(input int span);
      logic [lmc_pkg::OPC_W-1:0] opc;
      int                        arg;
      int                        roll;
      opc  = ($urandom_range(0, 99) < 4) ? lmc_pkg::INS_HLT
                                         : lmc_pkg::OPC_W'($urandom_range(1, 9));
      roll = $urandom_range(0, 99);
      if (opc == lmc_pkg::INS_IO)
         arg = (roll < 80) ? ((roll < 40) ? int'(lmc_pkg::IO_INP) : int'(lmc_pkg::IO_OUT))
                           : $urandom_range(0, 99);
      else if (roll < 85)
         arg = $urandom_range(0, span + 8);
      else if (roll < 92)
         arg = lmc_pkg::MAILBOX_COUNT - 1;
      else
         arg = $urandom_range(0, 99);
      return lmc_pkg::WORD_W'($urandom_range(0, 64) * lmc_pkg::DEC_BASE
                              + opc * lmc_pkg::DIGIT_BASE + arg);
   endfunction

   // drive one item, wait for acceptance, then record what it should return
   task automatic send_item(input logic [lmc_pkg::OP_W-1:0] op,
                            input logic [lmc_pkg::PC_W-1:0] addr,
                            input logic [lmc_pkg::WORD_W-1:0] wval,
                            input logic [lmc_pkg::WORD_W-1:0] ival,
                            input logic typed, input lmc_result_type want);
      lmc_result_type pred;
      // idling phases by item count
      if (items_sent < ITEM_TARGET / 3) begin
         send_idle_pct = 18;
         rsp_stall_pct = 74;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 74;
         rsp_stall_pct = 18;
      end else begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.address     <= addr;
      req_bus.write_value <= wval;
      req_bus.input_value <= ival;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = mailbox_machine_step(op, addr, wval, ival);
      awaited_results.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic send_random(input logic [lmc_pkg::OP_W-1:0] op,
                              input logic [lmc_pkg::PC_W-1:0] addr,
                              input logic [lmc_pkg::WORD_W-1:0] wval);
      send_item(op, addr, wval, lmc_pkg::WORD_W'($urandom), 1'b0, NO_WANT);
   endtask

   // stray item: any operation with any fields
   function automatic logic [lmc_pkg::OP_W-1:0] OP_OP_W_RANDOM();
      return lmc_pkg::OP_W'($urandom_range(0, 3));
   endfunction

   // load a small program and some data, start it and step it with interference
   task automatic run_program_episode();
      int len;
      int steps;
      int roll;
      len = $urandom_range(4, 24);
      for (int i = 0; i < len; i++)
         send_random(lmc_pkg::OP_WRITE, lmc_pkg::PC_W'(i), random_instr(len));
      repeat ($urandom_range(2, 6))
         send_random(lmc_pkg::OP_WRITE, lmc_pkg::PC_W'($urandom_range(0, len + 8)),
                     lmc_pkg::WORD_W'($urandom));
      send_random(lmc_pkg::OP_START, lmc_pkg::PC_W'($urandom_range(0, 127)),
                  lmc_pkg::WORD_W'($urandom));
      steps = $urandom_range(8, 50);
      for (int s = 0; s < steps; s++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            send_random(lmc_pkg::OP_READ, lmc_pkg::PC_W'($urandom_range(0, 127)),
                        lmc_pkg::WORD_W'($urandom));
         else if (roll < 12)
            send_random(lmc_pkg::OP_WRITE, lmc_pkg::PC_W'($urandom_range(0, len - 1)),
                        random_instr(len));
         else if (roll < 15)
            send_random(OP_OP_W_RANDOM(), lmc_pkg::PC_W'($urandom_range(0, 127)),
                        lmc_pkg::WORD_W'($urandom));
         else
            send_random(lmc_pkg::OP_STEP, lmc_pkg::PC_W'($urandom_range(0, 127)),
                        lmc_pkg::WORD_W'($urandom));
      end
   endtask

   // compare one accepted result with the oldest one awaited
   task automatic check_result();
      lmc_result_type got;
      lmc_result_type want;
      got = '{rsp_bus.read_value, rsp_bus.program_counter, rsp_bus.accumulator_value,
              rsp_bus.negative_flag, rsp_bus.output_valid, rsp_bus.input_taken,
              rsp_bus.halted};
      if (awaited_results.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("unexpected result: rv=%h pc=%0d acc=%h n=%b o=%b i=%b h=%b",
                     got.read_value, got.program_counter, got.accumulator_value,
                     got.negative_flag, got.output_valid, got.input_taken, got.halted);
      end else begin
         want = awaited_results.pop_front();
         if (got !== want) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("mismatch: exp rv=%h pc=%0d acc=%h n=%b o=%b i=%b h=%b",
                        want.read_value, want.program_counter, want.accumulator_value,
                        want.negative_flag, want.output_valid, want.input_taken,
                        want.halted);
               $display("          got rv=%h pc=%0d acc=%h n=%b o=%b i=%b h=%b",
                        got.read_value, got.program_counter, got.accumulator_value,
                        got.negative_flag, got.output_valid, got.input_taken, got.halted);
            end
         end
      end
   endtask

   // result side: check, then pick ready; one long hold-off to fill the block
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) check_result();
      if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
         hold_done     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // reset, stimulus and end of run
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = lmc_pkg::OP_READ;
      req_bus.address     = '0;
      req_bus.write_value = '0;
      req_bus.input_value = '0;
      rsp_bus.ready       = 1'b0;
      items_sent          = 0;
      fault_count         = 0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      hold_left           = 0;
      hold_done           = 1'b0;
      idle_cycles         = 0;
      mach_pc             = '0;
      mach_acc            = '0;
      mach_neg            = 1'b0;
      mach_halt           = 1'b1;
      for (int i = 0; i < lmc_pkg::MAILBOX_COUNT; i++) begin
         data_mem[i] = '0;
         code_opc[i] = '0;
         code_arg[i] = '0;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].wval,
                   DIRECTED_ROWS[i].ival, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // random programs
      while (items_sent < ITEM_TARGET)
         run_program_episode();
      req_bus.valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && awaited_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
